// ----- sv/tabp_pkg.sv -----
// Shared types and constants for the ternary adder bit propagator.
`timescale 1ns / 1ps
package tabp_pkg;

    localparam int MAX_WIDTH_DEF = 64;
    localparam int VEC_W         = 64;
    localparam int VEC_IDX_W     = 6;
    localparam int WIDTH_FLD_W   = 7;

    localparam logic [1:0] ST_UNCHANGED = 2'd0;
    localparam logic [1:0] ST_CHANGED   = 2'd1;
    localparam logic [1:0] ST_CONFLICT  = 2'd2;

    typedef struct packed {
        logic [WIDTH_FLD_W-1:0] width_in_use;
        logic [VEC_W-1:0]       a_known;
        logic [VEC_W-1:0]       a_value;
        logic [VEC_W-1:0]       b_known;
        logic [VEC_W-1:0]       b_value;
        logic [VEC_W-1:0]       sum_known;
        logic [VEC_W-1:0]       sum_value;
    } t_in_word;

    typedef struct packed {
        logic [VEC_W-1:0] a_known_out;
        logic [VEC_W-1:0] a_value_out;
        logic [VEC_W-1:0] b_known_out;
        logic [VEC_W-1:0] b_value_out;
        logic [VEC_W-1:0] sum_known_out;
        logic [VEC_W-1:0] sum_value_out;
        logic [1:0]       status;
    } t_out_word;

    // One bit column as seen by the column evaluator
    typedef struct packed {
        logic a_k;
        logic a_v;
        logic b_k;
        logic b_v;
        logic s_k;
        logic s_v;
        logic cin_valid;
        logic cin_val;
        logic cout_valid;
        logic cout_val;
    } t_col_in;

    typedef struct packed {
        logic conflict;
        logic cout_set;
        logic cout_val;
        logic s_fix;
        logic s_bit;
        logic a_fix;
        logic b_fix;
        logic ab_bit;
        logic cin_fix;
        logic changed;
    } t_col_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

endpackage

// ----- sv/tabp_col.sv -----
// Column evaluator: bounds on a + b + carry-in for one bit column.
`timescale 1ns / 1ps
module tabp_col (
    input  tabp_pkg::t_col_in  i_col,
    output tabp_pkg::t_col_out o_col
);
    import tabp_pkg::*;

    always_comb begin
        logic [2:0]        lb0;
        logic [2:0]        ub0;
        logic signed [3:0] lb;
        logic signed [3:0] ub;
        logic              a1;
        logic              a0;
        logic              b1;
        logic              b0;
        logic              s1;
        logic              s0;
        logic              cin_lo;
        logic              cin_hi;
        logic              settled;
        logic              ab_ok;

        a1 = i_col.a_k & i_col.a_v;
        a0 = i_col.a_k & ~i_col.a_v;
        b1 = i_col.b_k & i_col.b_v;
        b0 = i_col.b_k & ~i_col.b_v;
        s1 = i_col.s_k & i_col.s_v;
        s0 = i_col.s_k & ~i_col.s_v;
        cin_lo = i_col.cin_valid & i_col.cin_val;
        cin_hi = ~i_col.cin_valid | i_col.cin_val;

        lb0 = {2'b00, a1} + {2'b00, b1} + {2'b00, cin_lo};
        ub0 = {2'b00, ~a0} + {2'b00, ~b0} + {2'b00, cin_hi};
        lb  = signed'({1'b0, lb0});
        ub  = signed'({1'b0, ub0});

        // tighten by a known carry-out
        if (i_col.cout_valid && i_col.cout_val && lb < 4'sd2) begin
            lb = 4'sd2;
        end
        if (i_col.cout_valid && !i_col.cout_val && ub > 4'sd1) begin
            ub = 4'sd1;
        end
        // tighten by a known sum bit (parity)
        if (s1) begin
            if (!lb[0]) lb = lb + 4'sd1;
            if (!ub[0]) ub = ub - 4'sd1;
        end
        if (s0) begin
            if (lb[0]) lb = lb + 4'sd1;
            if (ub[0]) ub = ub - 4'sd1;
        end

        settled = (lb == ub);
        ab_ok   = settled && ((signed'({1'b0, lb0}) == lb) || (signed'({1'b0, ub0}) == lb));

        o_col.cout_set = (lb >= 4'sd2) || (ub <= 4'sd1);
        o_col.cout_val = (lb >= 4'sd2);
        o_col.s_bit    = lb[0];
        o_col.s_fix    = settled && !i_col.s_k;
        o_col.conflict = (lb > ub) || (settled && i_col.s_k && (i_col.s_v != lb[0]));
        o_col.ab_bit   = (signed'({1'b0, lb0}) != lb);
        o_col.a_fix    = ab_ok && !i_col.a_k;
        o_col.b_fix    = ab_ok && !i_col.b_k;
        o_col.cin_fix  = ab_ok && !i_col.cin_valid;
        o_col.changed  = o_col.s_fix | o_col.a_fix | o_col.b_fix;
    end

endmodule

// ----- sv/ternary_add_bit_propagator.sv -----
// Top level: sequencer and state for the ternary adder bit propagator.
`timescale 1ns / 1ps
// Propagates fixed bits through sum = a + b over the low width_in_use bits
// of three ternary vectors (known mask plus value). A word is taken when
// i_start is high and o_busy is low; o_busy then stays high until the result
// has been shown. The result on o_result is marked by o_done for exactly one
// cycle, and must be taken in that cycle: there is no way to hold it off.
// One column evaluator is shared by all columns and visits one bit column a
// cycle, lowest first. When a column fixes its own unknown carry-in the walk
// steps back one column and visits it and the column above again. Each step
// back fixes one of the width - 1 inner carries, so the steps back are bounded.
// A conflict ends the walk early. Widths above MAX_WIDTH are clipped to
// MAX_WIDTH; bits above the width pass through untouched. On a conflict the
// walk stops, status is 2 and the vectors keep whatever was fixed before it.
module ternary_add_bit_propagator #(
    parameter int MAX_WIDTH = tabp_pkg::MAX_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  tabp_pkg::t_in_word  i_cmd,
    output logic                o_busy,
    output logic                o_done,
    output tabp_pkg::t_out_word o_result
);
    import tabp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);

    t_state r_state, n_state;

    logic [VEC_W-1:0] r_ak, r_av, r_bk, r_bv, r_sk, r_sv;
    logic [CW-1:0]    r_width;
    logic [CW-1:0]    r_col;
    logic [MAX_WIDTH:0] r_cvalid;
    logic [MAX_WIDTH:0] r_cval;
    logic             r_changed;
    logic             r_conflict;

    logic                 w_accept;
    logic                 w_end;
    logic [CW-1:0]        w_col_nx;
    logic [CW-1:0]        w_next_col;
    logic [VEC_IDX_W-1:0] w_bit;
    logic [WIDTH_FLD_W-1:0] w_wsat;
    t_col_in              w_cin;
    t_col_out             w_cout;

    assign w_accept = i_start && !o_busy;
    assign w_end    = (r_col >= r_width);
    assign w_col_nx = CW'(r_col + 1'b1);
    assign w_bit    = VEC_IDX_W'(r_col);
    assign w_wsat   = (i_cmd.width_in_use > WIDTH_FLD_W'(MAX_WIDTH)) ?
                      WIDTH_FLD_W'(MAX_WIDTH) : i_cmd.width_in_use;

    // column after this one: step back one on a carry-in fix
    assign w_next_col = w_cout.cin_fix ?
                        ((r_col == '0) ? '0 : CW'(r_col - 1'b1)) : w_col_nx;

    assign w_cin.a_k        = r_ak[w_bit];
    assign w_cin.a_v        = r_av[w_bit];
    assign w_cin.b_k        = r_bk[w_bit];
    assign w_cin.b_v        = r_bv[w_bit];
    assign w_cin.s_k        = r_sk[w_bit];
    assign w_cin.s_v        = r_sv[w_bit];
    assign w_cin.cin_valid  = r_cvalid[r_col];
    assign w_cin.cin_val    = r_cval[r_col];
    assign w_cin.cout_valid = r_cvalid[w_col_nx];
    assign w_cin.cout_val   = r_cval[w_col_nx];

    tabp_col u_col (
        .i_col (w_cin),
        .o_col (w_cout)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_RUN;
            end
            S_RUN: begin
                if (w_end || w_cout.conflict) n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs from state
    always_comb begin
        o_busy = 1'b1;
        o_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
            end
            S_RUN: begin
                o_busy = 1'b1;
            end
            S_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_width    <= '0;
            r_cvalid   <= '0;
            r_cval     <= '0;
            r_changed  <= 1'b0;
            r_conflict <= 1'b0;
        end else if (r_state == S_IDLE) begin
            if (w_accept) begin
                r_ak       <= i_cmd.a_known;
                r_av       <= i_cmd.a_value;
                r_bk       <= i_cmd.b_known;
                r_bv       <= i_cmd.b_value;
                r_sk       <= i_cmd.sum_known;
                r_sv       <= i_cmd.sum_value;
                r_width    <= CW'(w_wsat);
                r_col      <= '0;
                // carry into bit 0 is a fixed zero
                r_cvalid   <= {{MAX_WIDTH{1'b0}}, 1'b1};
                r_cval     <= '0;
                r_changed  <= 1'b0;
                r_conflict <= 1'b0;
            end
        end else if (r_state == S_RUN && !w_end) begin
            if (w_cout.conflict) begin
                r_conflict <= 1'b1;
            end else begin
                if (w_cout.cout_set) begin
                    r_cvalid[w_col_nx] <= 1'b1;
                    r_cval[w_col_nx]   <= w_cout.cout_val;
                end
                if (w_cout.cin_fix) begin
                    r_cvalid[r_col] <= 1'b1;
                    r_cval[r_col]   <= w_cout.ab_bit;
                end
                if (w_cout.s_fix) begin
                    r_sk[w_bit] <= 1'b1;
                    r_sv[w_bit] <= w_cout.s_bit;
                end
                if (w_cout.a_fix) begin
                    r_ak[w_bit] <= 1'b1;
                    r_av[w_bit] <= w_cout.ab_bit;
                end
                if (w_cout.b_fix) begin
                    r_bk[w_bit] <= 1'b1;
                    r_bv[w_bit] <= w_cout.ab_bit;
                end
                r_changed <= r_changed | w_cout.changed;
                r_col     <= w_next_col;
            end
        end
    end

    assign o_result.a_known_out   = r_ak;
    assign o_result.a_value_out   = r_av;
    assign o_result.b_known_out   = r_bk;
    assign o_result.b_value_out   = r_bv;
    assign o_result.sum_known_out = r_sk;
    assign o_result.sum_value_out = r_sv;
    assign o_result.status        = r_conflict ? ST_CONFLICT :
                                    (r_changed ? ST_CHANGED : ST_UNCHANGED);

endmodule

// ----- verif/ternary_add_bit_propagator_tb.sv -----
// Self-checking testbench for the ternary adder bit propagator.
`timescale 1ns / 1ps
// Every word sent to the block also goes through a behavioural copy of the
// propagation. The copy walks the bit columns in the same way and steps back
// when a column fixes its own carry-in. Each result the block strobes out is
// compared field by field with the oldest prediction still pending.
// The stimulus comes in this order:
//   - directed words: width zero, widths at and above the maximum, fully
//     known vectors, a conflict after some bits have been fixed, carry-in
//     backtracking, and unknown value bits that must pass through
//   - random words that agree with a + b, with masks of varied density and
//     garbage in every unknown value bit
//   - more such words with one known bit flipped, to provoke conflicts
//   - pure noise
// The sender draws a random gap between words. One stretch runs with no gaps
// at all, so that i_start stays high from one word to the next.
module ternary_add_bit_propagator_tb;
    import tabp_pkg::*;

    localparam int CLK_HALF   = 10;
    localparam int FULL_SPAN  = 64;
    // Worst case per word: one visit per column, a revisit of the column below
    // and of this one for every carry-in fixed by a step back, plus set-up and result
    localparam int DRAIN_CYCLES = 3 * FULL_SPAN + 16;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    t_in_word  i_cmd;
    logic      o_busy;
    logic      o_done;
    t_out_word o_result;

    // Predicted outcomes, oldest first
    t_out_word predicted_domains_q[$];
    t_out_word oldest_prediction;
    int        mismatch_count;
    bit        no_gaps;

    ternary_add_bit_propagator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // ------------------------------------------------------------------
    // Behavioural propagation. Carry bookkeeping is one known flag and one
    // value per column boundary; boundary 0 is the fixed-zero carry-in.
    // ------------------------------------------------------------------
    function automatic t_out_word propagate_fixed_bits(input t_in_word w);
        t_out_word  r;
        bit [63:0]  ak, av, bk, bv, sk, sv;
        bit         carry_known [0:FULL_SPAN];
        bit         carry_bit   [0:FULL_SPAN];
        int         span, col, k, lb, ub, lb0, ub0;
        bit         stop, sbit, ab_bit, step_back;
        logic [1:0] st;

        ak = w.a_known;   av = w.a_value;
        bk = w.b_known;   bv = w.b_value;
        sk = w.sum_known; sv = w.sum_value;
        // widths past the maximum are clipped
        span = (int'(w.width_in_use) > FULL_SPAN) ? FULL_SPAN : int'(w.width_in_use);
        for (k = 0; k <= FULL_SPAN; k++) begin
            carry_known[k] = 1'b0;
            carry_bit[k]   = 1'b0;
        end
        carry_known[0] = 1'b1;
        st   = ST_UNCHANGED;
        stop = 1'b0;
        col  = 0;

        while (col < span && !stop) begin
            step_back = 1'b0;
            // bounds on a + b + carry-in for this column
            lb = int'(ak[col] & av[col]) + int'(bk[col] & bv[col])
               + (carry_known[col] ? int'(carry_bit[col]) : 0);
            ub = ((ak[col] & ~av[col]) ? 0 : 1) + ((bk[col] & ~bv[col]) ? 0 : 1)
               + (carry_known[col] ? int'(carry_bit[col]) : 1);
            lb0 = lb;
            ub0 = ub;

            // tighten by a known carry-out, then by the parity of a known sum bit
            if (carry_known[col+1] && carry_bit[col+1] && lb < 2) lb = 2;
            if (carry_known[col+1] && !carry_bit[col+1] && ub > 1) ub = 1;
            if (sk[col] && sv[col]) begin
                if (lb % 2 == 0) lb++;
                if (ub % 2 == 0) ub--;
            end
            if (sk[col] && !sv[col]) begin
                if (lb % 2 == 1) lb++;
                if (ub % 2 == 1) ub--;
            end

            if (lb > ub) begin
                st   = ST_CONFLICT;
                stop = 1'b1;
            end else begin
                if (lb >= 2) begin
                    carry_bit[col+1]   = 1'b1;
                    carry_known[col+1] = 1'b1;
                end else if (ub <= 1) begin
                    carry_bit[col+1]   = 1'b0;
                    carry_known[col+1] = 1'b1;
                end

                if (lb == ub) begin
                    sbit = (lb % 2 == 1);
                    if (!sk[col]) begin
                        sk[col] = 1'b1;
                        sv[col] = sbit;
                        st |= ST_CHANGED;
                    end else if (sv[col] != sbit) begin
                        st   = ST_CONFLICT;
                        stop = 1'b1;
                    end

                    // bound pinned to its original value: every free input
                    // of the column goes the same way
                    if (!stop && (lb0 == lb || ub0 == lb)) begin
                        ab_bit = (lb0 != lb);
                        if (!ak[col]) begin
                            ak[col] = 1'b1;
                            av[col] = ab_bit;
                            st |= ST_CHANGED;
                        end
                        if (!bk[col]) begin
                            bk[col] = 1'b1;
                            bv[col] = ab_bit;
                            st |= ST_CHANGED;
                        end
                        if (!carry_known[col]) begin
                            carry_bit[col]   = ab_bit;
                            carry_known[col] = 1'b1;
                            step_back        = 1'b1;
                        end
                    end
                end

                // a newly fixed carry-in sends the walk back one column
                if (!stop) col = step_back ? ((col > 0) ? col - 1 : 0) : col + 1;
            end
        end

        r.a_known_out   = ak;
        r.a_value_out   = av;
        r.b_known_out   = bk;
        r.b_value_out   = bv;
        r.sum_known_out = sk;
        r.sum_value_out = sv;
        r.status        = st;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking: o_done and o_result are read as they stood at the edge
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (predicted_domains_q.size() == 0) begin
                $error("result word with nothing pending: %h", o_result);
                mismatch_count++;
            end else begin
                oldest_prediction = predicted_domains_q.pop_front();
                compare_field("a_known_out",   oldest_prediction.a_known_out,
                              o_result.a_known_out);
                compare_field("a_value_out",   oldest_prediction.a_value_out,
                              o_result.a_value_out);
                compare_field("b_known_out",   oldest_prediction.b_known_out,
                              o_result.b_known_out);
                compare_field("b_value_out",   oldest_prediction.b_value_out,
                              o_result.b_value_out);
                compare_field("sum_known_out", oldest_prediction.sum_known_out,
                              o_result.sum_known_out);
                compare_field("sum_value_out", oldest_prediction.sum_value_out,
                              o_result.sum_value_out);
                compare_field("status", 64'(oldest_prediction.status),
                              64'(o_result.status));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic bit [63:0] rand_vec();
        return {$urandom, $urandom};
    endfunction

    // masks from empty to full, sparse and dense in between
    function automatic bit [63:0] rand_mask();
        bit [63:0] r1, r2, r3;
        r1 = rand_vec();
        r2 = rand_vec();
        r3 = rand_vec();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return '1;
            2:       return r1 & r2 & r3;
            3:       return r1 & r2;
            4:       return r1;
            5:       return r1 | r2;
            default: return r1 | r2 | r3;
        endcase
    endfunction

    // mostly in range; now and then zero or past the maximum
    function automatic int rand_width();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return $urandom_range(FULL_SPAN + 1, 127);
            2:       return FULL_SPAN;
            3:       return $urandom_range(1, 8);
            default: return $urandom_range(1, FULL_SPAN);
        endcase
    endfunction

    // known bits carry the true value; unknown value bits get garbage
    function automatic t_in_word make_word(input int width,
                                           input bit [63:0] a, b, s,
                                           input bit [63:0] ka, kb, ks);
        t_in_word w;
        w.width_in_use = WIDTH_FLD_W'(width);
        w.a_known      = ka;
        w.a_value      = (a & ka) | (rand_vec() & ~ka);
        w.b_known      = kb;
        w.b_value      = (b & kb) | (rand_vec() & ~kb);
        w.sum_known    = ks;
        w.sum_value    = (s & ks) | (rand_vec() & ~ks);
        return w;
    endfunction

    // Holds i_start high until the word is taken, then draws the gap.
    // With no gap i_start simply stays high for the next word.
    task automatic send_word(input t_in_word w);
        int gap;
        i_start <= 1'b1;
        i_cmd   <= w;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        predicted_domains_q.push_back(propagate_fixed_bits(w));
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        bit [63:0] a, b;
        t_in_word  w;
        a = rand_vec();
        b = rand_vec();

        // width zero: everything passes through, even an inconsistent sum
        send_word(make_word(0, 64'd1, 64'd1, 64'd0, '1, '1, '1));
        // single column, nothing known
        send_word(make_word(1, '0, '0, '0, '0, '0, '0));
        // all known and consistent: nothing to do
        send_word(make_word(FULL_SPAN, '1, 64'd1, 64'd0, '1, '1, '1));
        // addends known, sum free at full, just-under, just-over and far-over widths
        send_word(make_word(FULL_SPAN, a, b, a + b, '1, '1, '0));
        send_word(make_word(127, a, b, a + b, '1, '1, '0));
        send_word(make_word(FULL_SPAN + 1, '1, '1, '1 + '1, '1, '1, '0));
        send_word(make_word(FULL_SPAN - 1, '1, '1, '1 + '1, '1, '1, '0));
        // zeros known, sum bit 40 known one: low sum bits fixed, then conflict
        send_word(make_word(FULL_SPAN, '0, '0, 64'd1 << 40, '1, '1, 64'd1 << 40));
        // conflict in the very first column
        send_word(make_word(1, 64'd1, 64'd0, 64'd0, '1, '1, '1));
        // sum bit 1 set with bit-1 addends zero: carry-in fixed, walk steps back
        send_word(make_word(2, '0, '0, 64'd2, 64'd2, 64'd2, 64'd2));
        // same pattern at the top column of the full width
        send_word(make_word(FULL_SPAN, '0, '0, 64'd1 << 63, 64'd1 << 63,
                            64'd1 << 63, 64'd1 << 63));
        // sum all ones, a zero: b forced to all ones
        send_word(make_word(FULL_SPAN, '0, '1, '1, '1, '0, '1));
        // a all ones, sum zero: b forced to one, with a carry chain
        send_word(make_word(FULL_SPAN, '1, 64'd1, '0, '1, '0, '1));
        // nothing known, every value bit set: value bits must pass through
        w = '{width_in_use: 7'(FULL_SPAN), a_known: '0, a_value: '1,
              b_known: '0, b_value: '1, sum_known: '0, sum_value: '1};
        send_word(w);
        // everything known, all ones everywhere: conflict at column 0
        w = '{width_in_use: 7'(127), a_known: '1, a_value: '1,
              b_known: '1, b_value: '1, sum_known: '1, sum_value: '1};
        send_word(w);
        // sum known only, with both addends free; then a short word with one known a bit
        send_word(make_word(FULL_SPAN, a, b, a + b, '0, '0, '1));
        send_word(make_word(3, 64'd5, 64'd3, 64'd0, 64'd4, 64'd0, 64'd7));
    endtask

    // random a, b and sum = a + b; masks decide how much is revealed
    task automatic test_consistent_random(input int count);
        bit [63:0] a, b;
        int        n;
        for (n = 0; n < count; n++) begin
            // one back-to-back stretch so that i_start never drops
            no_gaps = (n >= count / 2 && n < count / 2 + 60);
            a = rand_vec();
            b = rand_vec();
            send_word(make_word(rand_width(), a, b, a + b,
                                rand_mask(), rand_mask(), rand_mask()));
        end
        no_gaps = 1'b0;
    endtask

    // well-formed words with one known bit flipped, not always within the width
    task automatic test_corrupted_random(input int count);
        bit [63:0] a, b, s, ka, kb, ks, flip;
        int        n;
        t_in_word  w;
        for (n = 0; n < count; n++) begin
            a  = rand_vec();
            b  = rand_vec();
            s  = a + b;
            ka = rand_mask();
            kb = rand_mask();
            ks = rand_mask() | rand_vec();
            flip = 64'd1 << $urandom_range(0, FULL_SPAN - 1);
            case ($urandom_range(0, 2))
                0:       s ^= flip;
                1:       a ^= flip;
                default: b ^= flip;
            endcase
            w = make_word($urandom_range(1, FULL_SPAN), a, b, s, ka | flip, kb | flip, ks);
            send_word(w);
        end
    endtask

    task automatic test_noise_random(input int count);
        int       n;
        t_in_word w;
        for (n = 0; n < count; n++) begin
            w.width_in_use = WIDTH_FLD_W'($urandom_range(0, 127));
            w.a_known      = rand_mask();
            w.a_value      = rand_vec();
            w.b_known      = rand_mask();
            w.b_value      = rand_vec();
            w.sum_known    = rand_mask();
            w.sum_value    = rand_vec();
            send_word(w);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        mismatch_count = 0;
        no_gaps        = 1'b0;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_cmd   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_consistent_random(400);
        test_corrupted_random(50);
        test_noise_random(50);

        i_start <= 1'b0;
        wait (predicted_domains_q.size() == 0);
        // room for any stray result to show up
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && predicted_domains_q.size() == 0) begin
            $display("ternary_add_bit_propagator_tb: PASS");
        end else begin
            $display("ternary_add_bit_propagator_tb: FAIL");
        end
        $finish;
    end

    // Watchdog: even with the longest walks and gaps the run needs about 2 ms
    initial begin
        #20000000;
        $display("ternary_add_bit_propagator_tb: FAIL");
        $finish;
    end

endmodule

// ----- ternary_add_bit_propagator.f -----
sv/tabp_pkg.sv
sv/tabp_col.sv
sv/ternary_add_bit_propagator.sv
verif/ternary_add_bit_propagator_tb.sv
